@@ sv/bmm_pkg.sv @@
// ----------------------------------------------------------------------------
// Block matrix multiply package
// Shared widths, command codes and the MAC pipeline control word.
// ----------------------------------------------------------------------------
package bmm_pkg;

  localparam int GRID_SIZE_DEF  = 16;
  localparam int BLOCK_SIZE_DEF = 2;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 5;
  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int VAL_W  = 37;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_A    = 2'd0,
    CMD_WR_B    = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_RD_C    = 2'd3
  } cmd_e;

  // One issued multiply-accumulate step
  typedef struct packed {
    logic vld;
    logic first;  // first term of a dot product
    logic last;   // last term, write the sum back
  } mac_ctl_t;

endpackage

@@ sv/bmm_ram.sv @@
// ----------------------------------------------------------------------------
// Block matrix multiply storage
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bmm_ram #(
  parameter int DATA_W = 16,
  parameter int ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

@@ sv/bmm_mac.sv @@
// ----------------------------------------------------------------------------
// Block matrix multiply MAC pipeline
// Takes A and B elements in the cycle after their read was issued, multiplies,
// accumulates a dot product and emits the write of each finished C element.
// ----------------------------------------------------------------------------
module bmm_mac #(
  parameter int ADDR_W = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bmm_pkg::mac_ctl_t         issue_i,
  input  logic [ADDR_W-1:0]         issue_addr_i,
  input  logic [bmm_pkg::ELEM_W-1:0] a_data_i,
  input  logic [bmm_pkg::ELEM_W-1:0] b_data_i,
  output logic                      c_we_o,
  output logic [ADDR_W-1:0]         c_addr_o,
  output logic [bmm_pkg::VAL_W-1:0] c_data_o,
  output logic                      busy_o
);
  import bmm_pkg::*;

  mac_ctl_t                   ctl1_q, ctl2_q;
  logic [ADDR_W-1:0]          addr1_q, addr2_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic [VAL_W-1:0]           acc_q;
  logic [VAL_W-1:0]           sum;

  // stage 1 lines up with the RAM read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q  <= '0;
      ctl2_q  <= '0;
      addr1_q <= '0;
      addr2_q <= '0;
      prod_q  <= '0;
      acc_q   <= '0;
    end else begin
      ctl1_q  <= issue_i;
      addr1_q <= issue_addr_i;
      ctl2_q  <= ctl1_q;
      addr2_q <= addr1_q;
      prod_q  <= $signed(a_data_i) * $signed(b_data_i);
      if (ctl2_q.vld) begin
        acc_q <= sum;
      end
    end
  end

  // sign-extend the product, wrap modulo 2^VAL_W
  assign sum = (ctl2_q.first ? '0 : acc_q) + VAL_W'(prod_q);

  assign c_we_o   = ctl2_q.vld & ctl2_q.last;
  assign c_addr_o = addr2_q;
  assign c_data_o = sum;
  assign busy_o   = ctl1_q.vld | ctl2_q.vld;

endmodule

@@ sv/block_matrix_multiply.sv @@
// ----------------------------------------------------------------------------
// Block matrix multiply
// Loads A and B element by element, computes C = A*B with one MAC per cycle
// out of A, B and C RAMs, and returns single C elements on request.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (low bit first)                    Width
// s_axis    in   cmd, elem_row, elem_col, elem_value        28 -> 32
// m_axis    out  out_row, out_col, out_value                47 -> 48
//
// Write A/B: the element is written as the item is taken. Read C: tready drops
// while the C RAM read is in flight. Compute: N^3 MACs (N = GRID_SIZE*BLOCK_SIZE),
// one MAC per cycle set by the single read port of the A and B RAMs, then the
// MAC pipeline drains; no item is taken meanwhile.
// Reset: C reads as zero until the first compute completes; no clearing pass.
// A result stalled on m_axis parks in a skid register; s_axis keeps taking
// items until that register is occupied.
// ----------------------------------------------------------------------------
module block_matrix_multiply #(
  parameter int GRID_SIZE  = bmm_pkg::GRID_SIZE_DEF,
  parameter int BLOCK_SIZE = bmm_pkg::BLOCK_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // cmd[1:0], elem_row[6:2], elem_col[11:7], elem_value[27:12], zeros
  input  logic [bmm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_row[4:0], out_col[9:5], out_value[46:10], zero
  output logic [bmm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import bmm_pkg::*;

  localparam int MAT_DIM = GRID_SIZE * BLOCK_SIZE;
  localparam int DIM_W   = (MAT_DIM > 1) ? $clog2(MAT_DIM) : 1;
  localparam int ADDR_W  = 2 * DIM_W;
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAT_DIM - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMP,
    S_DRAIN
  } state_e;

  state_e               state_q, state_d;
  logic [DIM_W-1:0]     r_q, r_d, c_q, c_d, k_q, k_d;
  logic                 c_ready_q, c_ready_d;

  cmd_e                 in_cmd;
  logic [IDX_W-1:0]     in_row, in_col;
  logic [ELEM_W-1:0]    in_value;
  logic                 in_acc, in_range;
  logic [ADDR_W-1:0]    in_addr;

  logic                 rd_pend_q, rd_hit_q;
  logic [IDX_W-1:0]     rd_row_q, rd_col_q;
  logic                 out_vld_q, skid_vld_q, out_free;
  logic [IDX_W-1:0]     out_row_q, out_col_q, skid_row_q, skid_col_q;
  logic [VAL_W-1:0]     out_val_q, skid_val_q, rd_val;

  mac_ctl_t             issue;
  logic [ELEM_W-1:0]    a_rdata, b_rdata;
  logic [VAL_W-1:0]     c_rdata, c_wdata;
  logic [ADDR_W-1:0]    c_waddr;
  logic                 c_we, mac_busy;

  assign in_cmd   = cmd_e'(s_axis_tdata[1:0]);
  assign in_row   = s_axis_tdata[6:2];
  assign in_col   = s_axis_tdata[11:7];
  assign in_value = s_axis_tdata[27:12];
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign in_range = (32'(in_row) < 32'(MAT_DIM)) && (32'(in_col) < 32'(MAT_DIM));
  assign in_addr  = {DIM_W'(in_row), DIM_W'(in_col)};

  assign s_axis_tready = (state_q == S_IDLE) && !rd_pend_q && !skid_vld_q;

  // ---- storage ----
  bmm_ram #(.DATA_W(ELEM_W), .ADDR_W(ADDR_W)) u_a_ram (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc && in_cmd == CMD_WR_A && in_range),
    .wr_addr_i (in_addr),
    .wr_data_i (in_value),
    .rd_addr_i ({r_q, k_q}),
    .rd_data_o (a_rdata)
  );

  bmm_ram #(.DATA_W(ELEM_W), .ADDR_W(ADDR_W)) u_b_ram (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc && in_cmd == CMD_WR_B && in_range),
    .wr_addr_i (in_addr),
    .wr_data_i (in_value),
    .rd_addr_i ({k_q, c_q}),
    .rd_data_o (b_rdata)
  );

  bmm_ram #(.DATA_W(VAL_W), .ADDR_W(ADDR_W)) u_c_ram (
    .clk_i     (clk_i),
    .wr_en_i   (c_we),
    .wr_addr_i (c_waddr),
    .wr_data_i (c_wdata),
    .rd_addr_i (in_addr),
    .rd_data_o (c_rdata)
  );

  // ---- MAC pipeline ----
  always_comb begin
    issue.vld   = (state_q == S_COMP);
    issue.first = (k_q == '0);
    issue.last  = (k_q == DIM_MAX);
  end

  bmm_mac #(.ADDR_W(ADDR_W)) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .issue_i      (issue),
    .issue_addr_i ({r_q, c_q}),
    .a_data_i     (a_rdata),
    .b_data_i     (b_rdata),
    .c_we_o       (c_we),
    .c_addr_o     (c_waddr),
    .c_data_o     (c_wdata),
    .busy_o       (mac_busy)
  );

  // ---- sequencer ----
  always_comb begin
    state_d   = state_q;
    r_d       = r_q;
    c_d       = c_q;
    k_d       = k_q;
    c_ready_d = c_ready_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_cmd == CMD_COMPUTE) begin
          state_d = S_COMP;
          r_d     = '0;
          c_d     = '0;
          k_d     = '0;
        end
      end
      S_COMP: begin
        if (k_q != DIM_MAX) begin
          k_d = k_q + 1'b1;
        end else begin
          k_d = '0;
          if (c_q != DIM_MAX) begin
            c_d = c_q + 1'b1;
          end else begin
            c_d = '0;
            if (r_q != DIM_MAX) begin
              r_d = r_q + 1'b1;
            end else begin
              state_d = S_DRAIN;
            end
          end
        end
      end
      S_DRAIN: begin
        if (!mac_busy) begin
          state_d   = S_IDLE;
          c_ready_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_free = !out_vld_q || m_axis_tready;
  assign rd_val   = rd_hit_q ? c_rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      r_q        <= '0;
      c_q        <= '0;
      k_q        <= '0;
      c_ready_q  <= 1'b0;
      rd_pend_q  <= 1'b0;
      rd_hit_q   <= 1'b0;
      rd_row_q   <= '0;
      rd_col_q   <= '0;
      out_vld_q  <= 1'b0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_val_q  <= '0;
      skid_vld_q <= 1'b0;
      skid_row_q <= '0;
      skid_col_q <= '0;
      skid_val_q <= '0;
    end else begin
      state_q   <= state_d;
      r_q       <= r_d;
      c_q       <= c_d;
      k_q       <= k_d;
      c_ready_q <= c_ready_d;

      rd_pend_q <= in_acc && in_cmd == CMD_RD_C;
      if (in_acc && in_cmd == CMD_RD_C) begin
        rd_row_q <= in_row;
        rd_col_q <= in_col;
        rd_hit_q <= in_range && c_ready_q;
      end

      // skid drains first; a fresh read result goes to whichever slot is free
      if (skid_vld_q) begin
        if (out_free) begin
          out_vld_q  <= 1'b1;
          out_row_q  <= skid_row_q;
          out_col_q  <= skid_col_q;
          out_val_q  <= skid_val_q;
          skid_vld_q <= 1'b0;
        end
      end else if (rd_pend_q) begin
        if (out_free) begin
          out_vld_q <= 1'b1;
          out_row_q <= rd_row_q;
          out_col_q <= rd_col_q;
          out_val_q <= rd_val;
        end else begin
          skid_vld_q <= 1'b1;
          skid_row_q <= rd_row_q;
          skid_col_q <= rd_col_q;
          skid_val_q <= rd_val;
        end
      end else if (out_free) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_val_q, out_col_q, out_row_q};

  // ---- assertions ----
  a_ready_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == S_IDLE)
    else $error("input taken outside idle");

  a_read_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |=> m_axis_tvalid)
    else $error("read result not presented");

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid occupied while output empty");

  a_cwrite_in_compute : assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_we |-> (state_q == S_COMP || state_q == S_DRAIN))
    else $error("C write outside compute");

  a_no_read_in_compute : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !rd_pend_q)
    else $error("C read overlaps compute");

endmodule

@@ tb/tb_block_matrix_multiply.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block matrix multiply testbench
// Loads A and B over s_axis, triggers products and reads C elements back.
// Every read is predicted from a local copy of the A, B and C stores and
// compared field by field as it leaves m_axis. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_block_matrix_multiply;

  import bmm_pkg::*;

  localparam int MAT_N      = GRID_SIZE_DEF * BLOCK_SIZE_DEF;
  localparam int MAT_CELLS  = MAT_N * MAT_N;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int TAIL_CYCLES = 100;

  typedef struct {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } c_elem_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // cmd, elem_row, elem_col, elem_value, zeros
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // out_row, out_col, out_value, zero

  logic signed [ELEM_W-1:0] a_mem       [MAT_CELLS];
  logic signed [ELEM_W-1:0] b_mem       [MAT_CELLS];
  logic        [VAL_W-1:0]  product_mem [MAT_CELLS];

  c_elem_t pending_c_reads [$];
  int      err_count = 0;
  int      cycle_count = 0;
  bit      src_idle_en;
  bit      sink_stall_en;

  block_matrix_multiply u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("mismatch %s: expected 0x%0h got 0x%0h (cycle %0d)",
             what, want, got, cycle_count);
    err_count++;
  endtask

  // Sum of products over the full matrices, wrapped to the result width
  function automatic void compute_product();
    longint acc;
    for (int r = 0; r < MAT_N; r++) begin
      for (int c = 0; c < MAT_N; c++) begin
        acc = 0;
        for (int k = 0; k < MAT_N; k++) begin
          acc += longint'(a_mem[r*MAT_N + k]) * longint'(b_mem[k*MAT_N + c]);
        end
        product_mem[r*MAT_N + c] = acc[VAL_W-1:0];
      end
    end
  endfunction

  function automatic void predict_matrix_op(input cmd_e cmd, input logic [IDX_W-1:0] row,
                                            input logic [IDX_W-1:0] col,
                                            input logic [ELEM_W-1:0] value);
    bit      in_range;
    int      idx;
    c_elem_t want;
    in_range = (int'(row) < MAT_N) && (int'(col) < MAT_N);
    idx      = in_range ? int'(row) * MAT_N + int'(col) : 0;
    case (cmd)
      CMD_WR_A: begin
        if (in_range) a_mem[idx] = value;
      end
      CMD_WR_B: begin
        if (in_range) b_mem[idx] = value;
      end
      CMD_COMPUTE: begin
        compute_product();
      end
      default: begin
        want.row   = row;
        want.col   = col;
        want.value = in_range ? product_mem[idx] : '0;
        pending_c_reads.push_back(want);
      end
    endcase
  endfunction

  // Present one command; tvalid stays high afterwards until the next call
  // or a drain lowers it at the following falling edge.
  task automatic send_command(input cmd_e cmd, input logic [IDX_W-1:0] row,
                              input logic [IDX_W-1:0] col,
                              input logic [ELEM_W-1:0] value);
    int gap;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, value, col, row, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_matrix_op(cmd, row, col, value);
  endtask

  // Hold the sender until every outstanding read has returned
  task automatic drain_reads();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_c_reads.size() != 0) @(posedge clk_i);
  endtask

  task automatic fill_matrix(input cmd_e which, input bit rand_vals,
                             input logic [ELEM_W-1:0] value);
    for (int r = 0; r < MAT_N; r++) begin
      for (int c = 0; c < MAT_N; c++) begin
        send_command(which, r[IDX_W-1:0], c[IDX_W-1:0],
                     rand_vals ? ELEM_W'($urandom) : value);
      end
    end
  endtask

  task automatic read_corners();
    send_command(CMD_RD_C, '0, '0, '0);
    send_command(CMD_RD_C, '0, IDX_W'(MAT_N - 1), 16'hffff);
    send_command(CMD_RD_C, IDX_W'(MAT_N - 1), '0, '0);
    send_command(CMD_RD_C, IDX_W'(MAT_N - 1), IDX_W'(MAT_N - 1), 16'h5a5a);
  endtask

  // C reads as zero out of reset and is untouched by loads alone
  task automatic test_reset_reads();
    read_corners();
    send_command(CMD_WR_A, 5'd3, 5'd7, 16'h7fff);
    send_command(CMD_WR_B, 5'd7, 5'd3, 16'h8000);
    send_command(CMD_RD_C, 5'd3, 5'd3, '0);
    drain_reads();
  endtask

  // Most negative operands everywhere give the largest positive sum
  task automatic test_max_positive_sum();
    fill_matrix(CMD_WR_A, 1'b0, 16'h8000);
    fill_matrix(CMD_WR_B, 1'b0, 16'h8000);
    send_command(CMD_RD_C, 5'd1, 5'd2, '0);
    send_command(CMD_COMPUTE, 5'd31, 5'd31, 16'hffff);
    read_corners();
    drain_reads();
  endtask

  // A full of the most negative value against a last B column of the most
  // positive one gives the most negative sums in the last C column
  task automatic test_max_negative_sum();
    for (int r = 0; r < MAT_N; r++) begin
      send_command(CMD_WR_B, r[IDX_W-1:0], IDX_W'(MAT_N - 1), 16'h7fff);
    end
    send_command(CMD_COMPUTE, '0, '0, '0);
    read_corners();
    drain_reads();
  endtask

  task automatic test_random_traffic();
    int   pick;
    cmd_e cmd;
    send_command(CMD_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
    for (int i = 0; i < 900; i++) begin
      if (i == 450) drain_reads();
      if (i == 750) begin
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
      end
      pick = $urandom_range(0, 9);
      if (i == 899 || pick >= 6) cmd = CMD_RD_C;
      else if (pick >= 3)        cmd = CMD_WR_B;
      else                       cmd = CMD_WR_A;
      if (i % 220 == 110) cmd = CMD_COMPUTE;
      send_command(cmd, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
    end
    drain_reads();
  endtask

  // Sink side: stall in random bursts while enabled
  always begin
    @(negedge clk_i);
    if (sink_stall_en && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin : result_check
    c_elem_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_c_reads.size() == 0) begin
        report_mismatch("unexpected result", '0, 64'(m_axis_tdata));
      end else begin
        want = pending_c_reads.pop_front();
        if (m_axis_tdata[4:0] !== want.row)
          report_mismatch("out_row", 64'(want.row), 64'(m_axis_tdata[4:0]));
        if (m_axis_tdata[9:5] !== want.col)
          report_mismatch("out_col", 64'(want.col), 64'(m_axis_tdata[9:5]));
        if (m_axis_tdata[46:10] !== want.value)
          report_mismatch("out_value", 64'(want.value), 64'(m_axis_tdata[46:10]));
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;
    for (int i = 0; i < MAT_CELLS; i++) begin
      a_mem[i]       = '0;
      b_mem[i]       = '0;
      product_mem[i] = '0;
    end
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_reads();
    test_max_positive_sum();
    test_max_negative_sum();
    test_random_traffic();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/bmm_pkg.sv
sv/bmm_ram.sv
sv/bmm_mac.sv
sv/block_matrix_multiply.sv
tb/tb_block_matrix_multiply.sv
